// ----- rtl/core/elfchk_pkg.sv -----
`timescale 1ns / 1ps

package elfchk_pkg;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MEMZERO   = 3'd1;
  localparam logic [2:0] ST_FILEGTMEM = 3'd2;
  localparam logic [2:0] ST_OFFPAST   = 3'd3;
  localparam logic [2:0] ST_DATAPAST  = 3'd4;
  localparam logic [2:0] ST_WRAP      = 3'd5;
  localparam logic [2:0] ST_NOLOAD    = 3'd6;
  localparam logic [2:0] ST_NOENTRY   = 3'd7;

  localparam logic [31:0] PT_LOAD = 32'd1;

  localparam logic       CFG_IMAGE_SIZE    = 1'b0;
  localparam logic       CFG_ENTRY_ADDRESS = 1'b1;

  localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [31:0] segment_type;
    logic [63:0] file_offset;
    logic [63:0] file_bytes;
    logic [63:0] mem_bytes;
    logic [63:0] virt_start;
    logic        last_header;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] load_segments;
    logic [63:0] lowest_start;
    logic [63:0] highest_end;
  } res_t;

  typedef struct packed {
    logic        load;
    logic        empty;
    logic [2:0]  err;
    logic        covers;
    logic [63:0] seg_end;
  } chk_t;

endpackage

// ----- rtl/core/elfchk_hdr_if.sv -----
`timescale 1ns / 1ps

interface elfchk_hdr_if;
  logic               valid;
  logic               ready;
  elfchk_pkg::hdr_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/elfchk_res_if.sv -----
`timescale 1ns / 1ps

interface elfchk_res_if;
  logic               valid;
  logic               ready;
  elfchk_pkg::res_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/elfchk_hdr_check.sv -----
`timescale 1ns / 1ps

module elfchk_hdr_check (
  input  elfchk_pkg::hdr_t   hdr,
  input  logic [31:0]        image_size,
  input  logic [63:0]        entry_address,
  output elfchk_pkg::chk_t   chk
);
  import elfchk_pkg::*;

  logic [64:0] vsum;
  logic [64:0] dsum;

  assign vsum = {1'b0, hdr.virt_start} + {1'b0, hdr.mem_bytes};
  assign dsum = {1'b0, hdr.file_offset} + {1'b0, hdr.file_bytes};

  always_comb begin
    chk.load    = (hdr.segment_type == PT_LOAD);
    chk.empty   = (hdr.mem_bytes == 64'd0) && (hdr.file_bytes == 64'd0);
    chk.seg_end = vsum[63:0];
    chk.covers  = (entry_address >= hdr.virt_start) && ({1'b0, entry_address} < vsum);
    if (hdr.mem_bytes == 64'd0) begin
      chk.err = ST_MEMZERO;
    end else if (hdr.file_bytes > hdr.mem_bytes) begin
      chk.err = ST_FILEGTMEM;
    end else if (hdr.file_offset > {32'd0, image_size}) begin
      chk.err = ST_OFFPAST;
    end else if (dsum > {33'd0, image_size}) begin
      chk.err = ST_DATAPAST;
    end else if (vsum[64]) begin
      chk.err = ST_WRAP;
    end else begin
      chk.err = ST_OK;
    end
  end

endmodule

// ----- rtl/core/elf_load_segment_checker_core.sv -----
`timescale 1ns / 1ps

// ELF64 program header checker. One header word is taken per clock; each header
// passes an input register, then parallel compares and adds that update the running
// segment count, address range, entry coverage and first error. A header marked last
// loads one result word from the input register into the result register and clears
// the running state. Only a last header waiting on a full, stalled result register holds
// the input; otherwise the block sustains one header per cycle. Write image_size
// (index 0) and entry_address (index 1) only between images.
module elf_load_segment_checker_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data,
  elfchk_hdr_if.sink           hdr,
  elfchk_res_if.source         res
);
  import elfchk_pkg::*;

  logic [31:0] image_size;
  logic [63:0] entry_address;

  logic        s1_valid;
  hdr_t        s1_hdr;
  logic        s1_go;

  logic [15:0] seg_count;
  logic [63:0] min_start;
  logic [63:0] max_end;
  logic        entry_seen;
  logic [2:0]  err_latch;

  logic [15:0] seg_count_next;
  logic [63:0] min_start_next;
  logic [63:0] max_end_next;
  logic        entry_seen_next;
  logic [2:0]  err_latch_next;

  logic        res_valid;
  res_t        res_data;
  res_t        res_data_next;

  chk_t        chk;
  logic        apply;
  logic        upd;

  elfchk_hdr_check u_check (
    .hdr           (s1_hdr),
    .image_size    (image_size),
    .entry_address (entry_address),
    .chk           (chk)
  );

  assign s1_go     = !(s1_hdr.last_header && res_valid && !res.ready);
  assign hdr.ready = !s1_valid || s1_go;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size    <= 32'd0;
      entry_address <= 64'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_SIZE:    image_size    <= cfg_data[31:0];
        CFG_ENTRY_ADDRESS: entry_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    apply = (err_latch == ST_OK) && chk.load && !chk.empty;
    upd   = apply && (chk.err == ST_OK);

    err_latch_next  = (apply && chk.err != ST_OK) ? chk.err : err_latch;
    seg_count_next  = seg_count;
    min_start_next  = min_start;
    max_end_next    = max_end;
    entry_seen_next = entry_seen;
    if (upd) begin
      if (seg_count != COUNT_MAX) begin
        seg_count_next = seg_count + 16'd1;
      end
      if (s1_hdr.virt_start < min_start) begin
        min_start_next = s1_hdr.virt_start;
      end
      if (chk.seg_end > max_end) begin
        max_end_next = chk.seg_end;
      end
      if (chk.covers) begin
        entry_seen_next = 1'b1;
      end
    end

    res_data_next = '0;
    if (err_latch_next != ST_OK) begin
      res_data_next.status = err_latch_next;
    end else if (seg_count_next == 16'd0) begin
      res_data_next.status = ST_NOLOAD;
    end else if (!entry_seen_next) begin
      res_data_next.status = ST_NOENTRY;
    end else begin
      res_data_next.status        = ST_OK;
      res_data_next.load_segments = seg_count_next;
      res_data_next.lowest_start  = min_start_next;
      res_data_next.highest_end   = max_end_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (hdr.ready) begin
      s1_valid <= hdr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.ready && hdr.valid) begin
      s1_hdr <= hdr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count  <= 16'd0;
      min_start  <= ALL_ONES64;
      max_end    <= 64'd0;
      entry_seen <= 1'b0;
      err_latch  <= ST_OK;
    end else if (s1_valid && s1_go) begin
      if (s1_hdr.last_header) begin
        seg_count  <= 16'd0;
        min_start  <= ALL_ONES64;
        max_end    <= 64'd0;
        entry_seen <= 1'b0;
        err_latch  <= ST_OK;
      end else begin
        seg_count  <= seg_count_next;
        min_start  <= min_start_next;
        max_end    <= max_end_next;
        entry_seen <= entry_seen_next;
        err_latch  <= err_latch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_go && s1_hdr.last_header) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go && s1_hdr.last_header) begin
      res_data <= res_data_next;
    end
  end

  a_err_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status != ST_OK) |->
      (res_data.load_segments == 16'd0 && res_data.lowest_start == 64'd0 &&
       res_data.highest_end == 64'd0))
    else $error("error result carries nonzero fields");

  a_ok_has_segments: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.status == ST_OK) |-> (res_data.load_segments != 16'd0))
    else $error("ok result with no segments");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_go && s1_hdr.last_header) |=>
      (seg_count == 16'd0 && err_latch == ST_OK && !entry_seen && res_valid))
    else $error("state not cleared after last header");

  a_hold_stalled_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_hdr.last_header && res_valid && !res.ready) |=>
      (s1_valid && $stable(s1_hdr) && $stable(res_data)))
    else $error("last header lost while result stalled");

endmodule
